[design/gbt_pkg.sv]
// ----------------------------------------------------------------------------
// gbt_pkg: shared types and constants of the graph traversal engine
// Field widths, result status codes and the result command struct that the
// sequencer hands to the result stage.
// ----------------------------------------------------------------------------
package gbt_pkg;

  // fixed field widths
  localparam int VERTEX_W = 5;
  localparam int COUNT_W  = 6;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_VISIT      = 2'd0,
    STATUS_EDGE_REJ   = 2'd1,
    STATUS_BAD_START  = 2'd2
  } status_e;

  // command from the sequencer to the result stage
  typedef struct packed {
    logic                emit;      // a new vertex was visited
    logic                finish;    // traversal over, flush the held visit as last
    logic                err;       // single error result
    status_e             err_status;
    logic [VERTEX_W-1:0] vertex;
  } res_cmd_t;

endpackage

[design/graph_bfs_dfs_traversal.sv]
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal: undirected graph store with BFS and DFS walks
// Adjacency lists live in a vertex memory (list head and visited mark) and an
// entry memory (target and link); a work memory serves as the BFS queue or
// the DFS stack. Each visited vertex comes out as one result transaction.
//
//  channel   ports                                        handshake
//  --------  -------------------------------------------  ------------------
//  command   action_i vertex_a_i vertex_b_i depth_first_i  start, busy
//  result    visited_vertex_o last_visit_o status_o        result_valid_o
//  config    cfg_data_i (vertex count)                     cfg_we_i
//
// An add-edge reads a's list head and writes the a -> b entry, then reads
// b's list head and writes the b -> a entry; a rejected edge or bad start
// gives its error result straight from idle. A traversal first runs the
// visited-map clearing sweep, then the BFS or DFS walk; each memory has a
// single read port. After reset busy stays high while the list heads are
// swept to null. Results are one-cycle strobes; the receiver cannot stall.
// ----------------------------------------------------------------------------
module graph_bfs_dfs_traversal #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         action_i,
  input  logic [gbt_pkg::VERTEX_W-1:0] vertex_a_i,
  input  logic [gbt_pkg::VERTEX_W-1:0] vertex_b_i,
  input  logic                         depth_first_i,
  input  logic                         cfg_we_i,
  input  logic [gbt_pkg::COUNT_W-1:0]  cfg_data_i,
  output logic                         result_valid_o,
  output logic [gbt_pkg::VERTEX_W-1:0] visited_vertex_o,
  output logic                         last_visit_o,
  output logic [1:0]                   status_o
);
  import gbt_pkg::*;

  localparam int SLOTS = 2 * MAX_EDGES;
  localparam int VIW   = $clog2(MAX_VERTICES);
  localparam int EIW   = $clog2(SLOTS);
  localparam int LW    = $clog2(SLOTS + 1);
  localparam int CW    = $clog2(MAX_VERTICES + 1);

  typedef struct packed {
    logic [LW-1:0] head;
    logic          seen;
  } vword_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] target;
    logic [LW-1:0]       link;
  } eword_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic [LW-1:0]       cursor;
  } wword_t;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE,
    ST_EDGE_WA, ST_EDGE_RB, ST_EDGE_WB,
    ST_CLEAR, ST_START,
    ST_BFS_MARK, ST_BFS_POP, ST_BFS_HEAD, ST_BFS_LIST, ST_BFS_TGT, ST_BFS_CHK,
    ST_DFS_MARK, ST_DFS_TOP, ST_DFS_CUR, ST_DFS_TGT, ST_DFS_CHK
  } state_e;

  state_e              state_q, state_d;
  logic [COUNT_W-1:0]  vc_q;
  logic [LW-1:0]       used_q, used_d;
  logic [CW-1:0]       sweep_q, sweep_d;
  logic [CW-1:0]       rd_q, rd_d;
  logic [CW-1:0]       wr_q, wr_d;
  logic [CW-1:0]       top_q, top_d;
  logic [CW-1:0]       n_q, n_d;
  logic [VERTEX_W-1:0] va_q, va_d;
  logic [VERTEX_W-1:0] vb_q, vb_d;
  logic                dfs_q, dfs_d;
  logic [LW-1:0]       ptr_q, ptr_d;

  logic [COUNT_W-1:0]  cnt;
  logic                accept;
  res_cmd_t            cmd;

  // memories and their ports
  vword_t              vmem [MAX_VERTICES];
  eword_t              emem [SLOTS];
  wword_t              wmem [MAX_VERTICES];

  logic                v_re, v_we;
  logic [VIW-1:0]      v_raddr, v_waddr;
  vword_t              v_wdata, v_rdata_q;
  logic                e_re, e_we;
  logic [EIW-1:0]      e_raddr, e_waddr;
  eword_t              e_wdata, e_rdata_q;
  logic                w_re, w_we;
  logic [VIW-1:0]      w_raddr, w_waddr;
  wword_t              w_wdata, w_rdata_q;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // effective vertex count
  always_comb begin
    if (int'(vc_q) < MAX_VERTICES) begin
      cnt = vc_q;
    end else begin
      cnt = COUNT_W'(MAX_VERTICES);
    end
  end

  // sequencer next state and memory controls
  always_comb begin
    state_d = state_q;
    used_d  = used_q;
    sweep_d = sweep_q;
    rd_d    = rd_q;
    wr_d    = wr_q;
    top_d   = top_q;
    n_d     = n_q;
    va_d    = va_q;
    vb_d    = vb_q;
    dfs_d   = dfs_q;
    ptr_d   = ptr_q;
    cmd     = '0;
    v_re    = 1'b0;
    v_we    = 1'b0;
    v_raddr = '0;
    v_waddr = '0;
    v_wdata = '0;
    e_re    = 1'b0;
    e_we    = 1'b0;
    e_raddr = '0;
    e_waddr = '0;
    e_wdata = '0;
    w_re    = 1'b0;
    w_we    = 1'b0;
    w_raddr = '0;
    w_waddr = '0;
    w_wdata = '0;

    unique case (state_q)
      // list heads swept to null after reset
      ST_INIT: begin
        v_we    = 1'b1;
        v_waddr = VIW'(sweep_q);
        v_wdata = '0;
        sweep_d = sweep_q + CW'(1);
        if (int'(sweep_q) == MAX_VERTICES - 1) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          va_d  = vertex_a_i;
          vb_d  = vertex_b_i;
          dfs_d = depth_first_i;
          if (!action_i) begin
            if (({1'b0, vertex_a_i} >= cnt) || ({1'b0, vertex_b_i} >= cnt) ||
                (int'(used_q) + 2 > SLOTS)) begin
              cmd.err        = 1'b1;
              cmd.err_status = STATUS_EDGE_REJ;
            end else begin
              v_re    = 1'b1;
              v_raddr = VIW'(vertex_a_i);
              state_d = ST_EDGE_WA;
            end
          end else begin
            if ({1'b0, vertex_a_i} >= cnt) begin
              cmd.err        = 1'b1;
              cmd.err_status = STATUS_BAD_START;
            end else begin
              sweep_d = '0;
              state_d = ST_CLEAR;
            end
          end
        end
      end

      // first direction: entry a -> b at the head of a's list
      ST_EDGE_WA: begin
        e_we    = 1'b1;
        e_waddr = EIW'(used_q);
        e_wdata = '{target: vb_q, link: v_rdata_q.head};
        v_we    = 1'b1;
        v_waddr = VIW'(va_q);
        v_wdata = '{head: used_q + LW'(1), seen: v_rdata_q.seen};
        state_d = ST_EDGE_RB;
      end

      ST_EDGE_RB: begin
        v_re    = 1'b1;
        v_raddr = VIW'(vb_q);
        state_d = ST_EDGE_WB;
      end

      // second direction: entry b -> a at the head of b's list
      ST_EDGE_WB: begin
        e_we    = 1'b1;
        e_waddr = EIW'(used_q + LW'(1));
        e_wdata = '{target: va_q, link: v_rdata_q.head};
        v_we    = 1'b1;
        v_waddr = VIW'(vb_q);
        v_wdata = '{head: used_q + LW'(2), seen: v_rdata_q.seen};
        used_d  = used_q + LW'(2);
        state_d = ST_IDLE;
      end

      // visited map cleared, reading ahead one entry to keep the list head
      ST_CLEAR: begin
        if (int'(sweep_q) < MAX_VERTICES) begin
          v_re    = 1'b1;
          v_raddr = VIW'(sweep_q);
        end
        if (sweep_q != '0) begin
          v_we    = 1'b1;
          v_waddr = VIW'(sweep_q - CW'(1));
          v_wdata = '{head: v_rdata_q.head, seen: 1'b0};
        end
        sweep_d = sweep_q + CW'(1);
        if (int'(sweep_q) == MAX_VERTICES) begin
          state_d = ST_START;
        end
      end

      ST_START: begin
        v_re    = 1'b1;
        v_raddr = VIW'(va_q);
        n_d     = '0;
        state_d = dfs_q ? ST_DFS_MARK : ST_BFS_MARK;
      end

      // breadth first: queue the start vertex
      ST_BFS_MARK: begin
        v_we    = 1'b1;
        v_waddr = VIW'(va_q);
        v_wdata = '{head: v_rdata_q.head, seen: 1'b1};
        w_we    = 1'b1;
        w_waddr = '0;
        w_wdata = '{vertex: va_q, cursor: '0};
        rd_d    = '0;
        wr_d    = CW'(1);
        state_d = ST_BFS_POP;
      end

      ST_BFS_POP: begin
        if ((rd_q < wr_q) && (int'(n_q) < MAX_VERTICES)) begin
          w_re    = 1'b1;
          w_raddr = VIW'(rd_q);
          rd_d    = rd_q + CW'(1);
          state_d = ST_BFS_HEAD;
        end else begin
          cmd.finish = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      ST_BFS_HEAD: begin
        v_re       = 1'b1;
        v_raddr    = VIW'(w_rdata_q.vertex);
        cmd.emit   = 1'b1;
        cmd.vertex = w_rdata_q.vertex;
        n_d        = n_q + CW'(1);
        state_d    = ST_BFS_LIST;
      end

      ST_BFS_LIST: begin
        if (v_rdata_q.head != '0) begin
          e_re    = 1'b1;
          e_raddr = EIW'(v_rdata_q.head - LW'(1));
          state_d = ST_BFS_TGT;
        end else begin
          state_d = ST_BFS_POP;
        end
      end

      ST_BFS_TGT: begin
        ptr_d   = e_rdata_q.link;
        v_re    = 1'b1;
        v_raddr = VIW'(e_rdata_q.target);
        state_d = ST_BFS_CHK;
      end

      // enqueue an unseen neighbour, then fetch the next list entry
      ST_BFS_CHK: begin
        if (!v_rdata_q.seen && (int'(wr_q) < MAX_VERTICES)) begin
          v_we    = 1'b1;
          v_waddr = VIW'(e_rdata_q.target);
          v_wdata = '{head: v_rdata_q.head, seen: 1'b1};
          w_we    = 1'b1;
          w_waddr = VIW'(wr_q);
          w_wdata = '{vertex: e_rdata_q.target, cursor: '0};
          wr_d    = wr_q + CW'(1);
        end
        if (ptr_q != '0) begin
          e_re    = 1'b1;
          e_raddr = EIW'(ptr_q - LW'(1));
          state_d = ST_BFS_TGT;
        end else begin
          state_d = ST_BFS_POP;
        end
      end

      // depth first: visit the start vertex and push it
      ST_DFS_MARK: begin
        v_we       = 1'b1;
        v_waddr    = VIW'(va_q);
        v_wdata    = '{head: v_rdata_q.head, seen: 1'b1};
        cmd.emit   = 1'b1;
        cmd.vertex = va_q;
        n_d        = CW'(1);
        w_we       = 1'b1;
        w_waddr    = '0;
        w_wdata    = '{vertex: va_q, cursor: v_rdata_q.head};
        top_d      = CW'(1);
        state_d    = ST_DFS_TOP;
      end

      ST_DFS_TOP: begin
        if (top_q == '0) begin
          cmd.finish = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          w_re    = 1'b1;
          w_raddr = VIW'(top_q - CW'(1));
          state_d = ST_DFS_CUR;
        end
      end

      ST_DFS_CUR: begin
        if (w_rdata_q.cursor == '0) begin
          top_d   = top_q - CW'(1);
          state_d = ST_DFS_TOP;
        end else begin
          e_re    = 1'b1;
          e_raddr = EIW'(w_rdata_q.cursor - LW'(1));
          state_d = ST_DFS_TGT;
        end
      end

      // advance the cursor of the top frame
      ST_DFS_TGT: begin
        w_we    = 1'b1;
        w_waddr = VIW'(top_q - CW'(1));
        w_wdata = '{vertex: w_rdata_q.vertex, cursor: e_rdata_q.link};
        v_re    = 1'b1;
        v_raddr = VIW'(e_rdata_q.target);
        state_d = ST_DFS_CHK;
      end

      // descend into an unseen neighbour
      ST_DFS_CHK: begin
        if (!v_rdata_q.seen && (int'(top_q) < MAX_VERTICES) &&
            (int'(n_q) < MAX_VERTICES)) begin
          v_we       = 1'b1;
          v_waddr    = VIW'(e_rdata_q.target);
          v_wdata    = '{head: v_rdata_q.head, seen: 1'b1};
          cmd.emit   = 1'b1;
          cmd.vertex = e_rdata_q.target;
          n_d        = n_q + CW'(1);
          w_we       = 1'b1;
          w_waddr    = VIW'(top_q);
          w_wdata    = '{vertex: e_rdata_q.target, cursor: v_rdata_q.head};
          top_d      = top_q + CW'(1);
        end
        state_d = ST_DFS_TOP;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      vc_q    <= COUNT_W'(32);
      used_q  <= '0;
      sweep_q <= '0;
      rd_q    <= '0;
      wr_q    <= '0;
      top_q   <= '0;
      n_q     <= '0;
      dfs_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      sweep_q <= sweep_d;
      rd_q    <= rd_d;
      wr_q    <= wr_d;
      top_q   <= top_d;
      n_q     <= n_d;
      dfs_q   <= dfs_d;
      if (cfg_we_i) begin
        vc_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    va_q  <= va_d;
    vb_q  <= vb_d;
    ptr_q <= ptr_d;
  end

  // vertex memory: list head and visited mark
  always_ff @(posedge clk_i) begin
    if (v_we) begin
      vmem[v_waddr] <= v_wdata;
    end
    if (v_re) begin
      v_rdata_q <= vmem[v_raddr];
    end
  end

  // entry memory: neighbour and next link
  always_ff @(posedge clk_i) begin
    if (e_we) begin
      emem[e_waddr] <= e_wdata;
    end
    if (e_re) begin
      e_rdata_q <= emem[e_raddr];
    end
  end

  // work memory: bfs queue or dfs stack
  always_ff @(posedge clk_i) begin
    if (w_we) begin
      wmem[w_waddr] <= w_wdata;
    end
    if (w_re) begin
      w_rdata_q <= wmem[w_raddr];
    end
  end

  // result stage
  gbt_result u_result (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .result_valid_o   (result_valid_o),
    .visited_vertex_o (visited_vertex_o),
    .last_visit_o     (last_visit_o),
    .status_o         (status_o)
  );

endmodule

[design/gbt_result.sv]
// ----------------------------------------------------------------------------
// gbt_result: result stage of the graph traversal engine
// Holds the most recent visit back by one so that the final visit of a
// traversal can carry the last flag, and drives the one-cycle result strobe.
// ----------------------------------------------------------------------------
module gbt_result (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gbt_pkg::res_cmd_t          cmd_i,
  output logic                       result_valid_o,
  output logic [gbt_pkg::VERTEX_W-1:0] visited_vertex_o,
  output logic                       last_visit_o,
  output logic [1:0]                 status_o
);
  import gbt_pkg::*;

  logic                pend_valid_q;
  logic [VERTEX_W-1:0] pend_vertex_q;

  // held visit and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q     <= 1'b0;
      pend_vertex_q    <= '0;
      result_valid_o   <= 1'b0;
      visited_vertex_o <= '0;
      last_visit_o     <= 1'b0;
      status_o         <= STATUS_VISIT;
    end else begin
      result_valid_o <= 1'b0;
      priority if (cmd_i.err) begin
        result_valid_o   <= 1'b1;
        visited_vertex_o <= '0;
        last_visit_o     <= 1'b1;
        status_o         <= cmd_i.err_status;
      end else if (cmd_i.emit) begin
        // release the previous visit, keep the new one back
        if (pend_valid_q) begin
          result_valid_o   <= 1'b1;
          visited_vertex_o <= pend_vertex_q;
          last_visit_o     <= 1'b0;
          status_o         <= STATUS_VISIT;
        end
        pend_valid_q  <= 1'b1;
        pend_vertex_q <= cmd_i.vertex;
      end else if (cmd_i.finish) begin
        // the held visit is the final one
        result_valid_o   <= pend_valid_q;
        visited_vertex_o <= pend_vertex_q;
        last_visit_o     <= 1'b1;
        status_o         <= STATUS_VISIT;
        pend_valid_q     <= 1'b0;
      end
    end
  end

endmodule
